### sv/idxl_pkg.sv
// Shared types and constants for the indexed linked list unit.
// Used by indexed_linked_list_unit; depends on nothing else.
package idxl_pkg;

    localparam int MAX_INDEX_DEF = 255;

    // Request codes.
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_GET    = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_RANGE   = 3'd1;
    localparam logic [2:0] ERR_MEMBER  = 3'd2;
    localparam logic [2:0] ERR_ANCHOR  = 3'd3;
    localparam logic [2:0] ERR_NOTHING = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] item;
        logic [7:0] after;
        logic [7:0] position;
    } t_in_item;

    typedef struct packed {
        logic [7:0] found_index;
        logic       is_member;
        logic [7:0] list_length;
        logic [7:0] first_index;
        logic [7:0] last_index;
        logic [2:0] error_code;
    } t_out_item;

    // One successor table entry: member flag and the following index.
    typedef struct packed {
        logic       member;
        logic [7:0] succ;
    } t_entry;

endpackage

### sv/idxl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the successor table of the indexed linked list unit.
module idxl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/indexed_linked_list_unit.sv
// Indexed linked list unit: ordered list of distinct indices kept in a successor table.
// Uses idxl_pkg for types and codes and idxl_ram for the table storage.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_stall, payload i_in_data);
//   each produces one result on the output channel (o_out_valid / i_out_stall,
//   payload o_out_data). One request is worked on at a time; o_in_stall is high
//   while a request is in progress.
//   All table reads go through one table read port. Errors found before a read,
//   and a get past the end of the list, give their result without a table read.
//   Clear sweeps the whole table, one entry per cycle.
//   After reset the same sweep runs with o_in_stall high and
//   produces no result; head, tail and length read zero.
//   A finished result sits in an output register. If the receiver stalls while a
//   result is waiting, the next request may still be taken and worked on, but its
//   result is held back until the waiting one has been transferred.
module indexed_linked_list_unit #(
    parameter int MAX_INDEX = idxl_pkg::MAX_INDEX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  idxl_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output idxl_pkg::t_out_item  o_out_data
);

    localparam int DEPTH = MAX_INDEX + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $bits(idxl_pkg::t_entry);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CLEAR     = 4'd1;
    localparam logic [3:0] S_INS_ITEM  = 4'd2;
    localparam logic [3:0] S_INS_AFTER = 4'd3;
    localparam logic [3:0] S_INS_LINK  = 4'd4;
    localparam logic [3:0] S_RM_HEAD   = 4'd5;
    localparam logic [3:0] S_RM_AFTER  = 4'd6;
    localparam logic [3:0] S_RM_VICTIM = 4'd7;
    localparam logic [3:0] S_RM_FREE   = 4'd8;
    localparam logic [3:0] S_GET_STEP  = 4'd9;
    localparam logic [3:0] S_GET_WAIT  = 4'd10;
    localparam logic [3:0] S_QUERY     = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [3:0]          r_state, n_state;
    idxl_pkg::t_in_item  r_req, n_req;
    logic [7:0]          r_head, n_head;
    logic [7:0]          r_tail, n_tail;
    logic [7:0]          r_count, n_count;
    logic [7:0]          r_found, n_found;
    logic                r_member, n_member;
    logic [2:0]          r_err, n_err;
    logic [7:0]          r_x, n_x;
    logic [7:0]          r_k, n_k;
    logic [7:0]          r_victim, n_victim;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_clr_reply, n_clr_reply;
    logic                r_out_valid, n_out_valid;
    idxl_pkg::t_out_item r_out, n_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    idxl_pkg::t_entry    ram_wentry;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    idxl_pkg::t_entry    rd;

    function automatic logic in_rng(input logic [7:0] x);
        return (x != 8'd0) && (32'(x) <= MAX_INDEX);
    endfunction

    idxl_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(EW'(ram_wentry)),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd = idxl_pkg::t_entry'(ram_rdata);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_found     = r_found;
        n_member    = r_member;
        n_err       = r_err;
        n_x         = r_x;
        n_k         = r_k;
        n_victim    = r_victim;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wentry  = '0;
        ram_raddr   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_data;
                    n_found  = 8'd0;
                    n_member = 1'b0;
                    n_err    = idxl_pkg::ERR_OK;
                    n_state  = S_DONE;
                    case (i_in_data.mode)
                        idxl_pkg::MODE_INSERT: begin
                            if (!in_rng(i_in_data.item)) begin
                                n_err = idxl_pkg::ERR_RANGE;
                            end else begin
                                ram_raddr = AW'(i_in_data.item);
                                n_state   = S_INS_ITEM;
                            end
                        end
                        idxl_pkg::MODE_REMOVE: begin
                            if (i_in_data.after == 8'd0) begin
                                if (r_count == 8'd0 || r_head == 8'd0) begin
                                    n_err = idxl_pkg::ERR_NOTHING;
                                end else begin
                                    ram_raddr = AW'(r_head);
                                    n_state   = S_RM_HEAD;
                                end
                            end else if (!in_rng(i_in_data.after)) begin
                                n_err = idxl_pkg::ERR_ANCHOR;
                            end else begin
                                ram_raddr = AW'(i_in_data.after);
                                n_state   = S_RM_AFTER;
                            end
                        end
                        idxl_pkg::MODE_GET: begin
                            if (!in_rng(i_in_data.position)) begin
                                n_err = idxl_pkg::ERR_RANGE;
                            end else if (i_in_data.position <= r_count) begin
                                n_x     = r_head;
                                n_k     = 8'd1;
                                n_state = S_GET_STEP;
                            end
                        end
                        idxl_pkg::MODE_QUERY: begin
                            if (!in_rng(i_in_data.item)) begin
                                n_err = idxl_pkg::ERR_RANGE;
                            end else begin
                                ram_raddr = AW'(i_in_data.item);
                                n_state   = S_QUERY;
                            end
                        end
                        idxl_pkg::MODE_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_INS_ITEM: begin
                if (rd.member) begin
                    n_err   = idxl_pkg::ERR_MEMBER;
                    n_state = S_DONE;
                end else if (r_req.after == 8'd0) begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(r_req.item);
                    ram_wentry = '{member: 1'b1, succ: r_head};
                    n_head     = r_req.item;
                    if (r_count == 8'd0) begin
                        n_tail = r_req.item;
                    end
                    n_count = r_count + 8'd1;
                    n_state = S_DONE;
                end else if (!in_rng(r_req.after)) begin
                    n_err   = idxl_pkg::ERR_ANCHOR;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = AW'(r_req.after);
                    n_state   = S_INS_AFTER;
                end
            end

            S_INS_AFTER: begin
                if (!rd.member) begin
                    n_err   = idxl_pkg::ERR_ANCHOR;
                    n_state = S_DONE;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(r_req.item);
                    ram_wentry = '{member: 1'b1, succ: rd.succ};
                    n_state    = S_INS_LINK;
                end
            end

            S_INS_LINK: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(r_req.after);
                ram_wentry = '{member: 1'b1, succ: r_req.item};
                if (r_tail == r_req.after) begin
                    n_tail = r_req.item;
                end
                n_count = r_count + 8'd1;
                n_state = S_DONE;
            end

            S_RM_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_head);
                n_head    = rd.succ;
                if (r_tail == r_head) begin
                    n_tail = 8'd0;
                end
                n_count = r_count - 8'd1;
                n_found = r_head;
                n_state = S_DONE;
            end

            S_RM_AFTER: begin
                if (!rd.member) begin
                    n_err   = idxl_pkg::ERR_ANCHOR;
                    n_state = S_DONE;
                end else if (rd.succ == 8'd0) begin
                    n_err   = idxl_pkg::ERR_NOTHING;
                    n_state = S_DONE;
                end else begin
                    n_victim  = rd.succ;
                    ram_raddr = AW'(rd.succ);
                    n_state   = S_RM_VICTIM;
                end
            end

            S_RM_VICTIM: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(r_req.after);
                ram_wentry = '{member: 1'b1, succ: rd.succ};
                if (r_tail == r_victim) begin
                    n_tail = r_req.after;
                end
                n_state = S_RM_FREE;
            end

            S_RM_FREE: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_victim);
                if (r_count != 8'd0) begin
                    n_count = r_count - 8'd1;
                end
                n_found = r_victim;
                n_state = S_DONE;
            end

            S_GET_STEP: begin
                if (r_k < r_req.position && r_x != 8'd0) begin
                    ram_raddr = AW'(r_x);
                    n_k       = r_k + 8'd1;
                    n_state   = S_GET_WAIT;
                end else begin
                    n_found = r_x;
                    n_state = S_DONE;
                end
            end

            S_GET_WAIT: begin
                n_x     = rd.succ;
                n_state = S_GET_STEP;
            end

            S_QUERY: begin
                if (rd.member) begin
                    n_member = 1'b1;
                    n_found  = rd.succ;
                end
                n_state = S_DONE;
            end

            S_CLEAR: begin
                // Every entry is written back to the not-member state.
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                n_head    = 8'd0;
                n_tail    = 8'd0;
                n_count   = 8'd0;
                if (r_clr_addr == AW'(MAX_INDEX)) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.found_index = r_found;
                    n_out.is_member   = r_member;
                    n_out.list_length = r_count;
                    n_out.first_index = r_head;
                    n_out.last_index  = r_tail;
                    n_out.error_code  = r_err;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_head      <= 8'd0;
            r_tail      <= 8'd0;
            r_count     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_found  <= n_found;
        r_member <= n_member;
        r_err    <= n_err;
        r_x      <= n_x;
        r_k      <= n_k;
        r_victim <= n_victim;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
